/* rtl/core/mhid_pkg.sv */
// shared types, constants and functions of the mt19937 hex identifier generator
`timescale 1ns / 1ps

package mhid_pkg;

	localparam int unsigned STATE_WORDS = 624;
	localparam int unsigned TW_M        = 397;
	localparam int unsigned IDX_W       = 10;

	localparam logic [31:0] SEED_MULT  = 32'd1812433253;
	localparam logic [31:0] TW_MATRIX  = 32'h9908_B0DF;
	localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t IDX_END   = idx_t'(STATE_WORDS);
	localparam idx_t IDX_LAST  = idx_t'(STATE_WORDS - 1);
	localparam idx_t FAR_SPLIT = idx_t'(STATE_WORDS - TW_M);
	localparam idx_t FAR_FWD   = idx_t'(TW_M);

	// datapath operation for the current cycle
	typedef enum logic [2:0] {
		OP_NONE,
		OP_SEED0,
		OP_SEED_MUL,
		OP_SEED_WR,
		OP_CUR_LOAD,
		OP_REGEN_WR,
		OP_CHAR
	} op_t;

	typedef struct packed {
		op_t        op;
		idx_t       wr_addr;
		idx_t       rd_addr_a;
		idx_t       rd_addr_b;
		logic [4:0] pos;
		logic       last;
	} mhid_cmd_t;

	typedef struct packed {
		logic out_free;
	} mhid_sts_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
		logic [6:0] ch;
		if (nib < 4'd10) begin
			ch = 7'd48 + 7'(nib);
		end else begin
			ch = 7'd55 + 7'(nib);
		end
		return ch;
	endfunction

endpackage

/* rtl/core/mhid_dp.sv */
// datapath: state word memory, seeding multiplier, twist and tempering, output register
`timescale 1ns / 1ps

module mhid_dp import mhid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] seed,
	input  mhid_cmd_t   cmd,
	output mhid_sts_t   sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  out_char,
	output logic [4:0]  out_pos,
	output logic        out_last
);

	logic [31:0] mem [STATE_WORDS];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;
	logic [31:0] prev_q;
	logic [31:0] prod_q;
	logic        out_valid_q;
	logic [6:0]  out_char_q;
	logic [4:0]  out_pos_q;
	logic        out_last_q;

	logic        wr_en;
	logic [31:0] wr_data;
	logic [31:0] seed_word;
	logic [31:0] regen_word;
	logic [31:0] twist_y;
	logic [31:0] seed_mix;
	logic [31:0] tempered;

	assign seed_word  = prod_q + 32'(cmd.wr_addr);
	assign twist_y    = {prev_q[31], rd_a_q[30:0]};
	assign regen_word = rd_b_q ^ (twist_y >> 1) ^ (twist_y[0] ? TW_MATRIX : 32'd0);
	assign seed_mix   = prev_q ^ (prev_q >> 30);
	assign tempered   = temper(rd_a_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_data = seed_word;
		unique case (cmd.op)
			OP_SEED0: begin
				wr_en   = 1'b1;
				wr_data = seed;
			end
			OP_SEED_WR: begin
				wr_en   = 1'b1;
				wr_data = seed_word;
			end
			OP_REGEN_WR: begin
				wr_en   = 1'b1;
				wr_data = regen_word;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cmd.wr_addr] <= wr_data;
		end
		rd_a_q <= mem[cmd.rd_addr_a];
		rd_b_q <= mem[cmd.rd_addr_b];
	end

	// previous seed word or current word of the twist, seeding product and output character fields
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_SEED0:                 prev_q <= seed;
			OP_SEED_WR:               prev_q <= seed_word;
			OP_CUR_LOAD, OP_REGEN_WR: prev_q <= rd_a_q;
			default:                  prev_q <= prev_q;
		endcase
		if (cmd.op == OP_SEED_MUL) begin
			prod_q <= SEED_MULT * seed_mix;
		end
		if (cmd.op == OP_CHAR) begin
			out_char_q <= hex_ascii(tempered[31:28]);
			out_pos_q  <= cmd.pos;
			out_last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_CHAR) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign out_pos      = out_pos_q;
	assign out_last     = out_last_q;

endmodule

/* rtl/core/mhid_ctrl.sv */
// controller: sequences seeding, regeneration and character generation
`timescale 1ns / 1ps

module mhid_ctrl import mhid_pkg::*; #(
	parameter int unsigned ID_CHARS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_reseed,
	output logic      in_ready,
	input  mhid_sts_t sts,
	output mhid_cmd_t cmd
);

	localparam int unsigned CNT_W = (ID_CHARS > 1) ? $clog2(ID_CHARS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ID_CHARS - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_WR,
		ST_GEN,
		ST_GEN_OUT,
		ST_PRE_RD,
		ST_PRE_LD,
		ST_RG_RD,
		ST_RG_WR
	} state_t;

	state_t           state_q;
	mhid_cmd_t        cmd_q;
	idx_t             idx_q;
	idx_t             k_q;
	logic             seeded_q;
	logic [CNT_W-1:0] cnt_q;

	idx_t nxt_k;
	idx_t far_k;

	assign nxt_k = (k_q == IDX_LAST) ? '0 : k_q + idx_t'(1);
	assign far_k = (k_q < FAR_SPLIT) ? k_q + FAR_FWD : k_q - FAR_SPLIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cmd_q    <= '0;
			idx_q    <= IDX_END;
			k_q      <= '0;
			seeded_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q <= '0;
						if (in_reseed || !seeded_q) begin
							cmd_q.op      <= OP_SEED0;
							cmd_q.wr_addr <= '0;
							k_q           <= idx_t'(1);
							state_q       <= ST_SEED_MUL;
						end else begin
							cmd_q.op <= OP_NONE;
							state_q  <= ST_GEN;
						end
					end else begin
						cmd_q.op <= OP_NONE;
					end
				end
				ST_SEED_MUL: begin
					cmd_q.op <= OP_SEED_MUL;
					state_q  <= ST_SEED_WR;
				end
				ST_SEED_WR: begin
					cmd_q.op      <= OP_SEED_WR;
					cmd_q.wr_addr <= k_q;
					if (k_q == IDX_LAST) begin
						idx_q    <= IDX_END;
						seeded_q <= 1'b1;
						state_q  <= ST_GEN;
					end else begin
						k_q     <= k_q + idx_t'(1);
						state_q <= ST_SEED_MUL;
					end
				end
				ST_GEN: begin
					cmd_q.op <= OP_NONE;
					// wait until no character is pending in the output register
					if (idx_q == IDX_END) begin
						state_q <= ST_PRE_RD;
					end else if (sts.out_free && cmd_q.op != OP_CHAR) begin
						cmd_q.rd_addr_a <= idx_q;
						state_q         <= ST_GEN_OUT;
					end
				end
				ST_GEN_OUT: begin
					cmd_q.op   <= OP_CHAR;
					cmd_q.pos  <= 5'(cnt_q);
					cmd_q.last <= (cnt_q == CNT_LAST);
					idx_q      <= idx_q + idx_t'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_GEN;
					end
				end
				ST_PRE_RD: begin
					cmd_q.op        <= OP_NONE;
					cmd_q.rd_addr_a <= '0;
					state_q         <= ST_PRE_LD;
				end
				ST_PRE_LD: begin
					cmd_q.op <= OP_CUR_LOAD;
					k_q      <= '0;
					state_q  <= ST_RG_RD;
				end
				ST_RG_RD: begin
					cmd_q.op        <= OP_NONE;
					cmd_q.rd_addr_a <= nxt_k;
					cmd_q.rd_addr_b <= far_k;
					state_q         <= ST_RG_WR;
				end
				ST_RG_WR: begin
					cmd_q.op      <= OP_REGEN_WR;
					cmd_q.wr_addr <= k_q;
					if (k_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= ST_GEN;
					end else begin
						k_q     <= k_q + idx_t'(1);
						state_q <= ST_RG_RD;
					end
				end
				default: begin
					cmd_q.op <= OP_NONE;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign cmd      = cmd_q;

endmodule

/* rtl/core/mt19937_hex_id_generator_top.sv */
// Each request on the slave stream yields ID_CHARS upper-case ASCII hex digits on the master
// stream, taken from the top nibble of successive tempered MT19937 words. The 624 state
// words sit in a single RAM with one write and two registered read ports. The first request
// after reset, and any request with reseed set, first seeds the state from the seed register
// one word at a time, a multiply state then a write state per word, with one 32x32 multiplier.
// Whenever the word index runs out the whole state is regenerated one word at a time, a read
// state then a write state per word (an order set by the two RAM read ports and the write-after-
// read order of the twist), i.e. once every 19.5 identifiers of 32 characters. Each character
// goes through the RAM read, tempering and the output register, and the next one starts only
// once the output register is free. One request is handled at a time; the output register
// holds the final character while the next request is accepted.
`timescale 1ns / 1ps

module mt19937_hex_id_generator_top import mhid_pkg::*; #(
	parameter int unsigned ID_CHARS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] reseed, [7:1] zero
	// character stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [6:0] hex_char, [11:7] char_position, [15:12] zero
	output logic        m_tlast
);

	logic [31:0] seed_q;
	mhid_cmd_t   cmd;
	mhid_sts_t   sts;
	logic [6:0]  out_char;
	logic [4:0]  out_pos;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			seed_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == 1'b0) ? seed_q : 32'd0;

	mhid_ctrl #(
		.ID_CHARS(ID_CHARS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_reseed(s_tdata[0]),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mhid_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.seed     (seed_q),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_char (out_char),
		.out_pos  (out_pos),
		.out_last (m_tlast)
	);

	assign m_tdata = {4'd0, out_pos, out_char};

endmodule

/* verif/tb_top.sv */
// testbench for the mt19937 hex identifier generator: random requests checked against a local twister
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned ID_LEN      = 32;
	localparam int unsigned TWIST_N     = 624;
	localparam int unsigned TWIST_M     = 397;
	localparam logic [31:0] TWIST_XOR   = 32'h9908_B0DF;
	localparam logic [31:0] MASK_HI     = 32'h8000_0000;
	localparam logic [31:0] MASK_LO     = 32'h7FFF_FFFF;
	localparam logic [31:0] INIT_MULT   = 32'd1812433253;
	localparam logic [2:0]  ADDR_SEED   = 3'd0;
	localparam logic [2:0]  ADDR_UNUSED = 3'd4;
	localparam int          CYCLE_LIMIT = 2000000;
	localparam int          RAND_PHASES = 4;
	localparam int          PHASE_ITEMS = 88;

	typedef struct packed {
		logic [6:0] hex_char;
		logic [4:0] char_position;
		logic       last_char;
	} id_char_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [0] reseed, [7:1] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [6:0] hex_char, [11:7] char_position, [15:12] zero
	logic        m_tlast;

	mt19937_hex_id_generator_top #(
		.ID_CHARS(ID_LEN)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// local copy of the generator state
	logic [31:0] seed_reg;
	logic [31:0] twist_words [TWIST_N];
	int unsigned twist_idx;
	bit          twist_seeded;

	bit       reseed_q [$];   // pending requests
	id_char_t id_chars [$];   // characters still to come
	int       err_cnt;
	int       cycle_cnt;
	int       req_cnt;
	int       char_cnt;
	int       rx_hold;

	function automatic void twister_seed();
		logic [31:0] p;
		twist_words[0] = seed_reg;
		for (int i = 1; i < TWIST_N; i++) begin
			p = twist_words[i-1];
			twist_words[i] = INIT_MULT * (p ^ (p >> 30)) + 32'(i);
		end
		twist_idx    = TWIST_N;
		twist_seeded = 1'b1;
	endfunction

	function automatic void twister_regen();
		int unsigned nxt;
		int unsigned far_k;
		logic [31:0] y;
		for (int unsigned k = 0; k < TWIST_N; k++) begin
			nxt   = (k + 1 < TWIST_N) ? k + 1 : 0;
			far_k = (k + TWIST_M) % TWIST_N;
			y = (twist_words[k] & MASK_HI) | (twist_words[nxt] & MASK_LO);
			twist_words[k] = twist_words[far_k] ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'h0);
		end
		twist_idx = 0;
	endfunction

	function automatic logic [31:0] twister_next();
		logic [31:0] y;
		if (twist_idx >= TWIST_N) begin
			twister_regen();
		end
		y = twist_words[twist_idx];
		twist_idx++;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & 32'h9D2C_5680);
		y = y ^ ((y << 15) & 32'hEFC6_0000);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic void predict_identifier(input bit reseed);
		logic [3:0] nib;
		id_char_t   c;
		if (reseed || !twist_seeded) begin
			twister_seed();
		end
		for (int unsigned x = 0; x < ID_LEN; x++) begin
			nib = 4'(twister_next() >> 28);
			c.hex_char      = (nib < 4'd10) ? 7'd48 + 7'(nib) : 7'd55 + 7'(nib);
			c.char_position = 5'(x);
			c.last_char     = (x + 1 == ID_LEN);
			id_chars.push_back(c);
		end
	endfunction

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_SEED) begin
			seed_reg = val;
		end
	endtask

	task automatic wait_drained();
		while (reseed_q.size() != 0 || s_tvalid || id_chars.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// request driver
	always @(posedge clk) begin
		bit acc;
		bit idle;
		acc  = s_tvalid && s_tready;
		idle = ($urandom_range(99) < 25) && !(req_cnt >= 120 && req_cnt < 200);
		if (acc) begin
			predict_identifier(s_tdata[0]);
			void'(reseed_q.pop_front());
			req_cnt++;
		end
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !acc) begin
			// hold the request until taken
		end else if (reseed_q.size() != 0 && !idle) begin
			s_tvalid <= 1'b1;
			s_tdata  <= {7'b0, reseed_q[0]};
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// character monitor
	always @(posedge clk) begin
		id_char_t c;
		bit idle;
		if (m_tvalid && m_tready) begin
			if (id_chars.size() == 0) begin
				$error("unexpected character: hex_char %0d, char_position %0d, last_char %0d",
					m_tdata[6:0], m_tdata[11:7], m_tlast);
				err_cnt++;
			end else begin
				c = id_chars.pop_front();
				if (m_tdata[6:0] !== c.hex_char) begin
					$error("hex_char: expected %0d, got %0d", c.hex_char, m_tdata[6:0]);
					err_cnt++;
				end
				if (m_tdata[11:7] !== c.char_position) begin
					$error("char_position: expected %0d, got %0d", c.char_position,
						m_tdata[11:7]);
					err_cnt++;
				end
				if (m_tlast !== c.last_char) begin
					$error("last_char: expected %0d, got %0d", c.last_char, m_tlast);
					err_cnt++;
				end
			end
			char_cnt++;
			// long back-pressure so the request side stalls
			if (char_cnt == 2000 || char_cnt == 9000) begin
				rx_hold = 700;
			end
		end
		idle = ($urandom_range(99) < 25) && !(char_cnt >= 4000 && char_cnt < 6500);
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !idle;
		end
	end

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		seed_reg     = '0;
		twist_idx    = TWIST_N;
		twist_seeded = 1'b0;
		err_cnt      = 0;
		cycle_cnt    = 0;
		req_cnt      = 0;
		char_cnt     = 0;
		rx_hold      = 0;
		for (int i = 0; i < TWIST_N; i++) begin
			twist_words[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset seed, first request seeds even without reseed
		@(negedge clk);
		reseed_q.push_back(1'b0);
		reseed_q.push_back(1'b0);
		reseed_q.push_back(1'b1);
		wait_drained();

		// new seed only takes effect on a reseed request
		cfg_write(ADDR_SEED, 32'hFFFF_FFFF);
		@(negedge clk);
		reseed_q.push_back(1'b0);
		reseed_q.push_back(1'b1);
		wait_drained();

		// write to an unused address is ignored
		cfg_write(ADDR_SEED, 32'd5489);
		cfg_write(ADDR_UNUSED, 32'hDEAD_BEEF);
		@(negedge clk);
		reseed_q.push_back(1'b1);
		wait_drained();

		// zero seed, enough identifiers to regenerate in mid identifier
		cfg_write(ADDR_SEED, 32'h0);
		@(negedge clk);
		reseed_q.push_back(1'b1);
		for (int i = 0; i < 19; i++) begin
			reseed_q.push_back(1'b0);
		end
		wait_drained();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 1) begin
				cfg_write(ADDR_SEED, 32'h0000_0001);
			end else begin
				cfg_write(ADDR_SEED, $urandom());
			end
			if (ph == 2) begin
				cfg_write(ADDR_UNUSED, $urandom());
			end
			@(negedge clk);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				reseed_q.push_back($urandom_range(99) < 6);
			end
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (err_cnt == 0 && id_chars.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
